// ----- sv/htfd_pkg.sv -----
// shared types, constants and the crc-8 step for the humidity/temperature frame decoder
// no dependencies
`timescale 1ns / 1ps

package htfd_pkg;

    // crc-8 generator x^8 + x^5 + x^4 + 1, initial value zero, no final xor
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [15:0] STATUS_MASK = 16'hFFFC;

    // conversion constants, results in hundredths
    localparam logic [14:0]        TEMP_SCALE  = 15'd17572;
    localparam logic [14:0]        HUM_SCALE   = 15'd12500;
    localparam logic signed [15:0] TEMP_OFFSET = -16'sd4685;
    localparam logic signed [15:0] HUM_OFFSET  = -16'sd600;

    // measurement kinds
    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_HUM  = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    // one complete frame handed from front to back
    typedef struct packed {
        logic [15:0] code;
        logic        crc_error;
        logic        kind;
    } htfd_frame_t;

    // one converted result
    typedef struct packed {
        logic [14:0] measurement;
        logic [15:0] raw_code;
        logic        crc_error;
        logic        kind;
    } htfd_result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/htfd_front.sv -----
// front end: takes bytes, tracks the frame position and the running crc
// depends on htfd_pkg
`timescale 1ns / 1ps

module htfd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic [1:0]           s_tuser,   // [0] frame_start, [1] kind
    output logic                 push_valid,
    input  logic                 push_ready,
    output htfd_pkg::htfd_frame_t push_frame
);
    import htfd_pkg::*;

    typedef enum logic [1:0] {
        POS_HIGH  = 2'd0,
        POS_LOW   = 2'd1,
        POS_CHECK = 2'd2
    } pos_t;

    pos_t       pos_reg, pos_next, pos_cur;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] low_reg, low_next;
    logic       take;

    assign s_tready = push_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        pos_cur    = s_tuser[0] ? POS_HIGH : pos_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        push_valid = 1'b0;
        push_frame.code      = {high_reg, low_reg} & STATUS_MASK;
        push_frame.crc_error = (crc_reg != s_tdata);
        push_frame.kind      = s_tuser[1];
        if (take) begin
            unique case (pos_cur)
                POS_LOW: begin
                    low_next = s_tdata;
                    crc_next = crc8_byte(crc_reg, s_tdata);
                    pos_next = POS_CHECK;
                end
                POS_CHECK: begin
                    push_valid = 1'b1;
                    crc_next   = 8'h00;
                    pos_next   = POS_HIGH;
                end
                default: begin
                    // first byte, forced start, or the unused position
                    high_next = s_tdata;
                    crc_next  = crc8_byte(8'h00, s_tdata);
                    pos_next  = POS_LOW;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_HIGH;
            crc_reg  <= 8'h00;
            high_reg <= 8'h00;
            low_reg  <= 8'h00;
        end else begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

endmodule

// ----- sv/htfd_queue.sv -----
// short frame queue between front and back end
// depends on htfd_pkg
`timescale 1ns / 1ps

module htfd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  htfd_pkg::htfd_frame_t push_frame,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output htfd_pkg::htfd_frame_t pop_frame
);
    import htfd_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    htfd_frame_t     mem [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CntW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_frame  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

// ----- sv/htfd_back.sv -----
// back end: scales the sensor code, adds the offset, holds the result for the receiver
// depends on htfd_pkg
`timescale 1ns / 1ps

module htfd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  htfd_pkg::htfd_frame_t  pop_frame,
    output logic                   out_valid,
    input  logic                   out_ready,
    output htfd_pkg::htfd_result_t out_result
);
    import htfd_pkg::*;

    // multiply stage
    logic        mul_valid_reg;
    logic [30:0] prod_reg;
    htfd_frame_t mul_frame_reg;
    // output stage
    logic         res_valid_reg;
    htfd_result_t res_reg;

    logic              res_load, mul_load;
    logic [14:0]       scale;
    logic signed [15:0] offset, value;

    assign res_load  = !res_valid_reg || out_ready;
    assign mul_load  = !mul_valid_reg || res_load;
    assign pop_ready = mul_load;

    assign scale  = (pop_frame.kind == KIND_HUM) ? HUM_SCALE : TEMP_SCALE;
    assign offset = (mul_frame_reg.kind == KIND_HUM) ? HUM_OFFSET : TEMP_OFFSET;
    assign value  = offset + $signed({1'b0, prod_reg[30:16]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (mul_load) begin
                mul_valid_reg <= pop_valid;
            end
            if (res_load) begin
                res_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_load && pop_valid) begin
            // full product fits 31 bits for the largest code and scale
            prod_reg      <= 31'(pop_frame.code) * 31'(scale);
            mul_frame_reg <= pop_frame;
        end
        if (res_load && mul_valid_reg) begin
            res_reg.measurement <= value[14:0];
            res_reg.raw_code    <= mul_frame_reg.code;
            res_reg.crc_error   <= mul_frame_reg.crc_error;
            res_reg.kind        <= mul_frame_reg.kind;
        end
    end

    assign out_valid  = res_valid_reg;
    assign out_result = res_reg;

endmodule

// ----- sv/humidity_temp_frame_decoder.sv -----
// top level of the humidity/temperature frame decoder
// depends on htfd_pkg, htfd_front, htfd_queue and htfd_back
//
// usage
//   the s_ channel carries one received sensor byte per item: data high byte,
//   data low byte, then the checksum byte. s_tuser[0] forces the byte to open a
//   new frame, s_tuser[1] gives the measurement kind and is read with the checksum
//   byte (0 temperature, 1 humidity).
//   the m_ channel gives one result item per three-byte frame: the converted value
//   in hundredths of a degree celsius or percent rh, the code with its two status
//   bits cleared, a crc mismatch flag and the echoed kind.
// throughput and data path
//   one byte item is taken every cycle while the frame queue is not full. the
//   checksum byte writes its frame into the frame queue, from which the frame
//   passes into the multiplier register and then through the offset adder into
//   the output register that drives m_.
// reset
//   aresetn low clears the byte position, the running crc and all valid flags.
// stalls
//   while m_tready is low the output register holds; the multiplier stage and a
//   two-frame queue keep filling, and s_tready drops only once the queue is full.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // byte channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [0] frame_start, [1] kind
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] measurement, [30:15] raw_code, [31] zero
    output logic [1:0]  m_tuser    // [0] crc_error, [1] kind
);
    import htfd_pkg::*;

    // front to queue
    logic         push_valid, push_ready;
    htfd_frame_t  push_frame;
    // queue to back
    logic         pop_valid, pop_ready;
    htfd_frame_t  pop_frame;
    // back to output
    htfd_result_t result;

    // byte position, crc and frame assembly
    htfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame)
    );

    // decouples the byte side from the conversion side
    htfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame)
    );

    // scaling and output register
    htfd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {1'b0, result.raw_code, result.measurement};
    assign m_tuser = {result.kind, result.crc_error};

endmodule
